// ===== rtl/core/wait_timer_table_defines.svh =====
// ----------------------------------------------------------------------------
// wait_timer_table_defines
// assertion macros shared by the wait timer table rtl
// ----------------------------------------------------------------------------
`ifndef WAIT_TIMER_TABLE_DEFINES_SVH
`define WAIT_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define WTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/wtt_pkg.sv =====
// ----------------------------------------------------------------------------
// wtt_pkg
// types and codes shared by the wait timer table modules
// ----------------------------------------------------------------------------
package wtt_pkg;

	localparam int ID_W  = 16;
	localparam int TIM_W = 12;
	localparam int OCC_W = 6;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		KIND_ADD_OK   = 2'd0,
		KIND_ADD_FULL = 2'd1,
		KIND_EXPIRED  = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [TIM_W-1:0] remaining;
		logic [TIM_W-1:0] run_time;
	} entry_t;

	typedef struct packed {
		kind_t            kind;
		logic [ID_W-1:0]  expired_id;
		logic [TIM_W-1:0] expired_run_time;
		logic [OCC_W-1:0] occupancy;
		logic             last;
	} result_t;

endpackage

// ===== rtl/core/wtt_ram.sv =====
// ----------------------------------------------------------------------------
// wtt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module wtt_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/wtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// wtt_ctrl
// table sequencer: adds, aging walk, expiry reporting and ring compaction
// ----------------------------------------------------------------------------
module wtt_ctrl #(
	parameter int CAPACITY = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        opcode,
	input  logic [wtt_pkg::ID_W-1:0]    proc_id,
	input  logic [wtt_pkg::TIM_W-1:0]   wait_time,
	input  logic [wtt_pkg::TIM_W-1:0]   run_time,
	input  logic [wtt_pkg::TIM_W-1:0]   elapsed,
	output logic                        ram_we,
	output logic [$clog2(CAPACITY)-1:0] ram_waddr,
	output wtt_pkg::entry_t             ram_wdata,
	output logic [$clog2(CAPACITY)-1:0] ram_raddr,
	input  wtt_pkg::entry_t             ram_rdata,
	output logic                        strobe,
	output wtt_pkg::result_t            res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] sum);
		logic [SW-1:0] red;
		red = (sum >= SW'(CAPACITY)) ? sum - SW'(CAPACITY) : sum;
		return red[AW-1:0];
	endfunction

	state_t            state_q;
	logic [AW-1:0]     base_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     held_q;
	logic [AW-1:0]     rd_q;
	logic [AW-1:0]     w_q;
	logic              rd_more_q;
	logic              v_s1;
	logic [wtt_pkg::TIM_W-1:0] el_q;
	logic              pend_v_q;
	wtt_pkg::result_t  pend_q;
	wtt_pkg::result_t  res_q;
	logic              strobe_q;

	logic              accept;
	logic              full;
	logic              expired;
	logic              done;
	logic              strobe_d;
	logic [AW-1:0]     add_pos;
	logic [CW-1:0]     held_dec;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q >= CW'(CAPACITY));
	assign add_pos  = wrap(SW'(base_q) + SW'(count_q));
	assign expired  = (ram_rdata.remaining <= el_q);
	assign done     = (state_q == ST_WALK) && !rd_more_q && !v_s1;
	assign held_dec = held_q - CW'(1);

	// a result leaves for an add, an empty tick, a displaced expiry or the walk end
	assign strobe_d = (state_q == ST_IDLE)
		? (accept && (opcode == wtt_pkg::OP_ADD || count_q == '0))
		: ((v_s1 && expired && pend_v_q) || done);

	assign ram_raddr = wrap(SW'(base_q) + SW'(rd_q));

	always_comb begin
		if (state_q == ST_WALK) begin
			ram_we    = v_s1 && !expired;
			ram_waddr = wrap(SW'(base_q) + SW'(w_q));
			ram_wdata = '{id: ram_rdata.id,
				remaining: ram_rdata.remaining - el_q,
				run_time: ram_rdata.run_time};
		end else begin
			ram_we    = accept && (opcode == wtt_pkg::OP_ADD) && !full;
			ram_waddr = add_pos;
			ram_wdata = '{id: proc_id, remaining: wait_time, run_time: run_time};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_q    <= '0;
			count_q   <= '0;
			n_q       <= '0;
			held_q    <= '0;
			rd_q      <= '0;
			w_q       <= '0;
			rd_more_q <= 1'b0;
			v_s1      <= 1'b0;
			el_q      <= '0;
			pend_v_q  <= 1'b0;
			pend_q    <= '0;
			res_q     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == wtt_pkg::OP_ADD) begin
							if (full) begin
								res_q <= '{kind: wtt_pkg::KIND_ADD_FULL, expired_id: '0,
									expired_run_time: '0,
									occupancy: wtt_pkg::OCC_W'(count_q), last: 1'b1};
							end else begin
								count_q <= count_q + CW'(1);
								res_q   <= '{kind: wtt_pkg::KIND_ADD_OK, expired_id: '0,
									expired_run_time: '0,
									occupancy: wtt_pkg::OCC_W'(count_q + CW'(1)),
									last: 1'b1};
							end
						end else if (count_q == '0) begin
							res_q    <= '{kind: wtt_pkg::KIND_NONE, expired_id: '0,
								expired_run_time: '0, occupancy: '0, last: 1'b1};
						end else begin
							el_q      <= elapsed;
							rd_q      <= AW'(count_q - CW'(1));
							w_q       <= AW'(count_q - CW'(1));
							rd_more_q <= 1'b1;
							v_s1      <= 1'b0;
							n_q       <= count_q;
							held_q    <= count_q;
							pend_v_q  <= 1'b0;
							state_q   <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					// read side: newest to oldest
					if (rd_more_q) begin
						rd_q      <= rd_q - AW'(1);
						rd_more_q <= (rd_q != '0);
						v_s1      <= 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					// evaluate entry read last cycle
					if (v_s1) begin
						if (expired) begin
							held_q <= held_dec;
							if (pend_v_q) begin
								res_q    <= pend_q;
							end
							pend_q   <= '{kind: wtt_pkg::KIND_EXPIRED,
								expired_id: ram_rdata.id,
								expired_run_time: ram_rdata.run_time,
								occupancy: wtt_pkg::OCC_W'(held_dec), last: 1'b0};
							pend_v_q <= 1'b1;
						end else begin
							w_q <= w_q - AW'(1);
						end
					end
					// survivors now sit at the top of the old span
					if (done) begin
						count_q  <= held_q;
						base_q   <= wrap(SW'(base_q) + SW'(n_q - held_q));
						if (pend_v_q) begin
							res_q <= '{kind: pend_q.kind, expired_id: pend_q.expired_id,
								expired_run_time: pend_q.expired_run_time,
								occupancy: pend_q.occupancy, last: 1'b1};
						end else begin
							res_q <= '{kind: wtt_pkg::KIND_NONE, expired_id: '0,
								expired_run_time: '0,
								occupancy: wtt_pkg::OCC_W'(held_q), last: 1'b1};
						end
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign res    = res_q;

endmodule

// ===== rtl/core/wait_timer_table.sv =====
// an add answers in the cycle after its transfer; busy stays low
// a tick holding n entries is walked with one ram read per entry
// expiry results leave at most one per cycle during the walk, the final one at its end
// an empty tick answers in the cycle after its transfer
// reset clears the entry count and ring base; table contents need no clearing
// results cannot be stalled: each is shown for one cycle with strobe high
// ----------------------------------------------------------------------------
// wait_timer_table
// bounded table of waiting processes with aging, expiry and compaction
// ----------------------------------------------------------------------------
`include "wait_timer_table_defines.svh"

module wait_timer_table #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [15:0] proc_id,
	input  logic [11:0] wait_time,
	input  logic [11:0] run_time,
	input  logic [11:0] elapsed,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [15:0] expired_id,
	output logic [11:0] expired_run_time,
	output logic [5:0]  occupancy,
	output logic        last
);

	localparam int AW = $clog2(CAPACITY);

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	wtt_pkg::entry_t   ram_wdata;
	wtt_pkg::entry_t   ram_rdata;
	wtt_pkg::result_t  res;

	wtt_ram #(
		.WIDTH($bits(wtt_pkg::entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wtt_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.proc_id   (proc_id),
		.wait_time (wait_time),
		.run_time  (run_time),
		.elapsed   (elapsed),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.strobe    (strobe),
		.res       (res)
	);

	assign kind             = res.kind;
	assign expired_id       = res.expired_id;
	assign expired_run_time = res.expired_run_time;
	assign occupancy        = res.occupancy;
	assign last             = res.last;

	`WTT_ASSERT_NEXT(a_add_answers, clk, arst_n, start && !busy && opcode == wtt_pkg::OP_ADD, strobe && last && !busy, "add transfer without a final result")
	`WTT_ASSERT_NEXT(a_tick_progress, clk, arst_n, start && !busy && opcode == wtt_pkg::OP_TICK, busy || (strobe && last && kind == wtt_pkg::KIND_NONE), "tick transfer neither walking nor answered")
	`WTT_ASSERT_NOW(a_walk_ends_last, clk, arst_n, $fell(busy), strobe && last, "walk ended without a final result")
	`WTT_ASSERT_NOW(a_add_fields_zero, clk, arst_n, strobe && (kind == wtt_pkg::KIND_ADD_OK || kind == wtt_pkg::KIND_ADD_FULL), last && expired_id == '0 && expired_run_time == '0, "add result with expiry fields set")

endmodule
